[rtl/dpsd_pkg.sv]
// ----------------------------------------------------------------------------
// dpsd_pkg
// Shared types, constants and sample tables of the profile sample decoder.
// ----------------------------------------------------------------------------
package dpsd_pkg;

  typedef enum logic [3:0] {
    K_PD, K_RBT, K_TEMP, K_PRES, K_DEPTH, K_HEART, K_BEAR, K_ALARM, K_TIME,
    K_SKIP8, K_SKIPN
  } kind_e;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TYPE   = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  localparam logic [0:0] REG_FORMAT = 1'b0;
  localparam logic [0:0] REG_TRIMIX = 1'b1;

  localparam logic [2:0] FMT_NIBBLE = 3'd4;
  localparam logic [15:0] RBT_RESET = 16'd99;

  typedef struct packed {
    kind_e      kind;
    logic       absol;
    logic [1:0] idx;
    logic [3:0] ntype;
    logic       ign;
    logic [1:0] extra;
  } rom_row_t;

  typedef struct packed {
    logic       valid;
    rom_row_t   row;
  } rom_hit_t;

  typedef struct packed {
    logic [23:0] sample_time;
    logic [7:0]  repeat_count;
    logic [23:0] temperature_raw;
    logic [23:0] alarm_bits;
    logic [15:0] remaining_bottom_time;
    logic [3:0]  tank_index;
    logic [23:0] pressure_raw;
    logic [15:0] heart_rate;
    logic [15:0] compass_bearing;
    logic [23:0] depth_raw;
    logic [6:0]  present_flags;
    logic [1:0]  status;
  } result_t;

  function automatic rom_row_t mk(kind_e k, logic a, logic [1:0] i, logic [3:0] n,
                                  logic g, logic [1:0] e);
    rom_row_t r;
    r.kind = k; r.absol = a; r.idx = i; r.ntype = n; r.ign = g; r.extra = e;
    return r;
  endfunction

  function automatic rom_hit_t rom_lookup(logic [2:0] fmt, logic [4:0] id);
    rom_hit_t h;
    h.valid = 1'b1;
    h.row = mk(K_PD, 1'b0, 2'd0, 4'd0, 1'b0, 2'd0);
    case (fmt)
      3'd0, 3'd1: begin
        case (id)
          5'd0: h.row = mk(K_DEPTH, 0, 0, 1, 0, 0);
          5'd1: h.row = mk(K_TEMP, 0, 0, 2, 0, 0);
          5'd2: h.row = mk(K_TIME, 1, 0, 3, 0, 0);
          5'd3: h.row = mk(K_ALARM, 1, 0, 4, 0, 0);
          5'd4: h.row = mk(K_DEPTH, 0, 0, 5, 0, 1);
          5'd5: h.row = mk(K_TEMP, 0, 0, 6, 0, 1);
          5'd6: h.row = mk(K_DEPTH, 1, 0, 7, 1, 2);
          5'd7: h.row = mk(K_TEMP, 1, 0, 8, 0, 2);
          5'd8: begin
            h.row = mk(K_ALARM, 1, 1, 9, 0, 0);
            h.valid = (fmt == 3'd1);
          end
          default: h.valid = 1'b0;
        endcase
      end
      3'd2: begin
        case (id)
          5'd0:  h.row = mk(K_PD, 0, 0, 1, 0, 1);
          5'd1:  h.row = mk(K_RBT, 0, 0, 2, 0, 0);
          5'd2:  h.row = mk(K_TEMP, 0, 0, 3, 0, 0);
          5'd3:  h.row = mk(K_PRES, 0, 0, 4, 0, 1);
          5'd4:  h.row = mk(K_DEPTH, 0, 0, 5, 0, 1);
          5'd5:  h.row = mk(K_TEMP, 0, 0, 6, 0, 1);
          5'd6:  h.row = mk(K_ALARM, 1, 0, 7, 1, 1);
          5'd7:  h.row = mk(K_TIME, 1, 0, 8, 0, 1);
          5'd8:  h.row = mk(K_DEPTH, 1, 0, 9, 1, 2);
          5'd9:  h.row = mk(K_PRES, 1, 0, 10, 1, 2);
          5'd10: h.row = mk(K_TEMP, 1, 0, 11, 1, 2);
          5'd11: h.row = mk(K_RBT, 1, 0, 12, 1, 1);
          default: h.valid = 1'b0;
        endcase
      end
      3'd3: begin
        case (id)
          5'd0:  h.row = mk(K_PD, 0, 0, 1, 0, 1);
          5'd1:  h.row = mk(K_RBT, 0, 0, 2, 0, 0);
          5'd2:  h.row = mk(K_TEMP, 0, 0, 3, 0, 0);
          5'd3:  h.row = mk(K_PRES, 0, 0, 4, 0, 1);
          5'd4:  h.row = mk(K_DEPTH, 0, 0, 5, 0, 1);
          5'd5:  h.row = mk(K_TEMP, 0, 0, 6, 0, 1);
          5'd6:  h.row = mk(K_ALARM, 1, 0, 7, 1, 1);
          5'd7:  h.row = mk(K_TIME, 1, 0, 8, 0, 1);
          5'd8:  h.row = mk(K_DEPTH, 1, 0, 9, 1, 2);
          5'd9:  h.row = mk(K_TEMP, 1, 0, 10, 1, 2);
          5'd10: h.row = mk(K_PRES, 1, 0, 11, 1, 2);
          5'd11: h.row = mk(K_PRES, 1, 1, 12, 1, 2);
          5'd12: h.row = mk(K_PRES, 1, 2, 13, 1, 2);
          5'd13: h.row = mk(K_RBT, 1, 0, 14, 1, 1);
          default: h.valid = 1'b0;
        endcase
      end
      3'd4: begin
        case (id)
          5'd0:  h.row = mk(K_DEPTH, 0, 0, 1, 0, 0);
          5'd1:  h.row = mk(K_RBT, 0, 0, 3, 0, 0);
          5'd2:  h.row = mk(K_PRES, 0, 0, 4, 0, 0);
          5'd3:  h.row = mk(K_TEMP, 0, 0, 4, 0, 0);
          5'd4:  h.row = mk(K_TIME, 1, 0, 4, 0, 0);
          5'd5:  h.row = mk(K_HEART, 0, 0, 4, 0, 0);
          5'd6:  h.row = mk(K_ALARM, 1, 0, 4, 0, 0);
          5'd7:  h.row = mk(K_ALARM, 1, 1, 8, 0, 1);
          5'd8:  h.row = mk(K_DEPTH, 1, 0, 8, 0, 2);
          5'd9:  h.row = mk(K_RBT, 1, 0, 8, 0, 1);
          5'd10: h.row = mk(K_TEMP, 1, 0, 8, 0, 2);
          5'd11: h.row = mk(K_PRES, 1, 0, 8, 0, 2);
          5'd12: h.row = mk(K_PRES, 1, 1, 8, 0, 2);
          5'd13: h.row = mk(K_PRES, 1, 2, 8, 0, 2);
          5'd14: h.row = mk(K_HEART, 1, 0, 8, 0, 1);
          5'd15: h.row = mk(K_BEAR, 1, 0, 8, 0, 2);
          5'd16: h.row = mk(K_ALARM, 1, 2, 8, 0, 1);
          5'd17: h.row = mk(K_SKIP8, 1, 0, 8, 0, 0);
          5'd18: h.row = mk(K_SKIPN, 1, 0, 8, 0, 1);
          default: h.valid = 1'b0;
        endcase
      end
      default: h.valid = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic [4:0] table_size(logic [2:0] fmt);
    logic [4:0] n;
    case (fmt)
      3'd0: n = 5'd8;
      3'd1: n = 5'd9;
      3'd2: n = 5'd12;
      3'd3: n = 5'd14;
      3'd4: n = 5'd19;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/dpsd_in_if.sv]
// ----------------------------------------------------------------------------
// dpsd_in_if / dpsd_out_if / dpsd_cfg_if
// Valid/ready channels of the profile sample decoder.
// ----------------------------------------------------------------------------
interface dpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;
  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface dpsd_out_if;
  logic              valid;
  logic              ready;
  dpsd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [2:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/dive_profile_sample_decoder_top.sv]
// ----------------------------------------------------------------------------
// dive_profile_sample_decoder_top
// Decodes a dive profile bitstream into sample records.
// ----------------------------------------------------------------------------
// The in channel takes one profile byte per item with an end-of-stream mark.
// The out channel gives one record per completed time step, or an error
// record after which decoding halts. The cfg channel writes the format
// (index 0) and trimix mode (index 1); any write drops a partial sample.
// Each byte is decoded in the cycle it is accepted: prefix code, table
// lookup, sign extension and accumulator update are one combinational pass,
// and the record lands in the output register, or in the skid buffer
// during a stall, on the same clock edge. Throughput is one byte per cycle
// while in_ready is high. The output register and a one-entry skid buffer
// let bytes keep flowing while the receiver stalls; in_ready drops only
// when both are full. Reset clears all accumulators, sets remaining bottom
// time to 99 and selects format 0. After the final byte, or after an error
// record, no further records appear until reset.
// ----------------------------------------------------------------------------
module dive_profile_sample_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpsd_in_if.sink     in_if,
  dpsd_out_if.source  out_if,
  dpsd_cfg_if.sink    cfg_if
);

  logic [2:0]  fmt_q;
  logic        trimix_q;
  dpsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  ones_q, ones_d;
  logic [4:0]  entry_q, entry_d;
  logic [7:0]  left_q, left_d;
  logic [23:0] vacc_q, vacc_d;
  logic [4:0]  vbits_q, vbits_d;
  logic [23:0] time_q, time_d, temp_q, temp_d, pres_q, pres_d, dep_q, dep_d;
  logic [23:0] doff_q, doff_d, alarm_q, alarm_d;
  logic [15:0] rbt_q, rbt_d, heart_q, heart_d, bear_q, bear_d;
  logic [3:0]  tank_q, tank_d;
  logic        cal_q, cal_d, halt_q, halt_d;
  logic [6:0]  have_q, have_d;

  dpsd_pkg::result_t res, out_q, skid_q;
  logic        emit, out_vld_q, skid_vld_q;
  logic        acc, cfg_acc;

  assign in_if.ready  = !skid_vld_q;
  assign cfg_if.ready = 1'b1;
  assign acc     = in_if.valid && in_if.ready;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  function automatic logic [23:0] sext(logic [23:0] x, logic [4:0] n);
    logic [23:0] m;
    logic [23:0] r;
    if (n == 5'd0 || n > 5'd24) begin
      r = '0;
    end else begin
      m = 24'hFFFFFF << n;
      r = x[n - 5'd1] ? (x | m) : (x & ~m);
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        eos, hv, fin, fail, comp_any;
    logic [1:0]  fcode;
    logic [3:0]  k;
    logic [4:0]  id, nb;
    logic [5:0]  oid;
    logic [7:0]  complete;
    logic [7:0]  skip;
    logic [23:0] v, sv, val;
    logic [4:0]  sh;
    logic [6:0]  f;
    dpsd_pkg::rom_hit_t h;
    b = in_if.stream_byte;
    eos = in_if.end_of_stream;
    phase_d = phase_q; ones_d = ones_q; entry_d = entry_q; left_d = left_q;
    vacc_d = vacc_q; vbits_d = vbits_q; time_d = time_q; rbt_d = rbt_q;
    tank_d = tank_q; pres_d = pres_q; dep_d = dep_q; doff_d = doff_q;
    cal_d = cal_q; temp_d = temp_q; heart_d = heart_q; bear_d = bear_q;
    alarm_d = alarm_q; have_d = have_q; halt_d = halt_q;
    fin = 1'b0; fail = 1'b0; fcode = dpsd_pkg::ST_OK; complete = '0; skip = '0;
    emit = 1'b0; k = '0; id = '0; nb = '0; val = '0; oid = '0;
    hv = 1'b0; v = '0; sv = '0; sh = '0; f = '0;
    h = dpsd_pkg::rom_lookup(fmt_q, entry_q);
    res = '0;
    if (acc && !halt_q) begin
      case (phase_q)
        dpsd_pkg::PH_SKIP: begin
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) phase_d = dpsd_pkg::PH_TYPE;
          else if (eos) begin fail = 1'b1; fcode = dpsd_pkg::ST_INCOMPLETE; end
        end
        dpsd_pkg::PH_DATA: begin
          vacc_d = {vacc_q[15:0], b};
          vbits_d = vbits_q + 5'd8;
          left_d = left_q - 8'd1;
          if (left_d != 8'd0) begin
            if (eos) begin fail = 1'b1; fcode = dpsd_pkg::ST_INCOMPLETE; end
          end else fin = 1'b1;
        end
        default: begin
          if (dpsd_pkg::table_size(fmt_q) == 5'd0) begin
            fail = 1'b1; fcode = dpsd_pkg::ST_BAD_TYPE;
          end else begin
            hv = 1'b1;
            if (fmt_q == dpsd_pkg::FMT_NIBBLE) begin
              if (!b[7]) id = 5'd0;
              else if (b[7:5] == 3'b100) id = 5'd1;
              else if (b[7:4] != 4'hF) id = {2'b00, b[6:4]};
              else id = {1'b0, b[3:0]} + 5'd7;
              h = dpsd_pkg::rom_lookup(fmt_q, id);
              if (h.row.ntype < 4'd8) begin
                nb = 5'd8 - {1'b0, h.row.ntype};
                val = {16'd0, b} & ~(24'hFFFFFF << nb);
              end
            end else begin
              k = 4'd8;
              for (int i = 7; i >= 0; i--) begin
                if (!b[i] && k == 4'd8) k = 4'(7 - i);
              end
              if (k == 4'd8) begin
                hv = 1'b0;
                ones_d = ones_q + 4'd8;
                if ({1'b0, ones_d} >= dpsd_pkg::table_size(fmt_q) || eos ||
                    ones_q[3]) begin
                  fail = 1'b1; fcode = dpsd_pkg::ST_BAD_TYPE;
                end
              end else begin
                oid = {2'b00, ones_q} + {2'b00, k};
                id = oid[4:0];
                ones_d = '0;
                h = dpsd_pkg::rom_lookup(fmt_q, id);
                nb = 5'd7 - {1'b0, k};
                val = {16'd0, b} & ~(24'hFFFFFF << nb);
              end
            end
            if (hv) begin
              if (!h.valid) begin
                fail = 1'b1; fcode = dpsd_pkg::ST_BAD_TYPE;
              end else begin
                if (h.row.ign) begin nb = '0; val = '0; end
                entry_d = id; vacc_d = val; vbits_d = nb;
                left_d = {6'd0, h.row.extra};
                if (h.row.extra != 2'd0) begin
                  if (eos) begin fail = 1'b1; fcode = dpsd_pkg::ST_INCOMPLETE; end
                  else phase_d = dpsd_pkg::PH_DATA;
                end else fin = 1'b1;
              end
            end
          end
        end
      endcase
      if (fin) begin
        v = vacc_d;
        sv = sext(v, vbits_d);
        phase_d = dpsd_pkg::PH_TYPE;
        case (h.row.kind)
          dpsd_pkg::K_PD: begin
            pres_d = pres_q + {{16{sv[15]}}, sv[15:8]};
            dep_d = dep_q + {{16{sv[7]}}, sv[7:0]};
            complete = 8'd1;
          end
          dpsd_pkg::K_RBT: begin
            if (h.row.absol) begin rbt_d = v[15:0]; have_d[2] = 1'b1; end
            else rbt_d = rbt_q + sv[15:0];
          end
          dpsd_pkg::K_TEMP: begin
            if (h.row.absol) begin temp_d = sv; have_d[0] = 1'b1; end
            else temp_d = temp_q + sv;
          end
          dpsd_pkg::K_PRES: begin
            if (h.row.absol) begin
              if (trimix_q && fmt_q == dpsd_pkg::FMT_NIBBLE) begin
                tank_d = v[15:12]; pres_d = {12'd0, v[11:0]};
              end else begin
                tank_d = {2'b00, h.row.idx}; pres_d = v;
              end
              have_d[3] = 1'b1;
            end else pres_d = pres_q + sv;
          end
          dpsd_pkg::K_DEPTH: begin
            if (h.row.absol) begin
              dep_d = v;
              if (!cal_q) begin cal_d = 1'b1; doff_d = v; end
              have_d[6] = 1'b1;
            end else dep_d = dep_q + sv;
            complete = 8'd1;
          end
          dpsd_pkg::K_HEART: begin
            if (h.row.absol) begin heart_d = v[15:0]; have_d[4] = 1'b1; end
            else heart_d = heart_q + sv[15:0];
          end
          dpsd_pkg::K_BEAR: begin
            bear_d = v[15:0]; have_d[5] = 1'b1;
          end
          dpsd_pkg::K_ALARM: begin
            sh = {h.row.idx, 3'b000};
            if (h.row.idx != 2'd3)
              alarm_d = (alarm_q & ~(24'hFF << sh)) | ({16'd0, v[7:0]} << sh);
            have_d[1] = 1'b1;
          end
          dpsd_pkg::K_TIME: complete = v[7:0];
          dpsd_pkg::K_SKIP8: skip = 8'd8;
          default: begin
            if (v[7:0] == 8'd0) begin fail = 1'b1; fcode = dpsd_pkg::ST_INCOMPLETE; end
            else skip = v[7:0] - 8'd1;
          end
        endcase
        if (!fail) begin
          if (skip != 8'd0) begin
            if (eos) begin fail = 1'b1; fcode = dpsd_pkg::ST_INCOMPLETE; end
            else begin left_d = skip; phase_d = dpsd_pkg::PH_SKIP; end
          end else if (complete != 8'd0) begin
            emit = 1'b1;
            f = have_d;
            if (f[3]) f[2] = 1'b1;
            res.sample_time = time_q;
            res.repeat_count = complete;
            res.temperature_raw = f[0] ? temp_d : '0;
            res.alarm_bits = f[1] ? alarm_d : '0;
            res.remaining_bottom_time = f[2] ? rbt_d : '0;
            res.tank_index = f[3] ? tank_d : '0;
            res.pressure_raw = f[3] ? pres_d : '0;
            res.heart_rate = f[4] ? heart_d : '0;
            res.compass_bearing = f[5] ? bear_d : '0;
            res.depth_raw = f[6] ? (dep_d - doff_d) : '0;
            res.present_flags = f;
            res.status = dpsd_pkg::ST_OK;
            time_d = time_q + {14'd0, complete, 2'b00};
            alarm_d = '0;
            have_d[1] = 1'b0; have_d[5] = 1'b0;
          end
        end
      end
      if (fail) begin
        res = '0;
        res.status = fcode;
        emit = 1'b1;
        halt_d = 1'b1;
      end
      if (eos) halt_d = 1'b1;
    end
    comp_any = cfg_acc;
    if (comp_any) begin
      phase_d = dpsd_pkg::PH_TYPE; ones_d = '0; left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0; trimix_q <= 1'b0;
      phase_q <= dpsd_pkg::PH_TYPE; ones_q <= '0; entry_q <= '0; left_q <= '0;
      vacc_q <= '0; vbits_q <= '0; time_q <= '0; rbt_q <= dpsd_pkg::RBT_RESET;
      tank_q <= '0; pres_q <= '0; dep_q <= '0; doff_q <= '0; cal_q <= 1'b0;
      temp_q <= '0; heart_q <= '0; bear_q <= '0; alarm_q <= '0; have_q <= '0;
      halt_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_if.index)
          dpsd_pkg::REG_FORMAT: fmt_q <= cfg_if.wdata;
          dpsd_pkg::REG_TRIMIX: trimix_q <= cfg_if.wdata[0];
          default: ;
        endcase
      end
      phase_q <= phase_d; ones_q <= ones_d; entry_q <= entry_d; left_q <= left_d;
      vacc_q <= vacc_d; vbits_q <= vbits_d; time_q <= time_d; rbt_q <= rbt_d;
      tank_q <= tank_d; pres_q <= pres_d; dep_q <= dep_d; doff_q <= doff_d;
      cal_q <= cal_d; temp_q <= temp_d; heart_q <= heart_d; bear_q <= bear_d;
      alarm_q <= alarm_d; have_q <= have_d; halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_if.ready) begin
        out_vld_q <= skid_vld_q || emit;
        skid_vld_q <= 1'b0;
      end else if (emit) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_if.ready) begin
      out_q <= skid_vld_q ? skid_q : res;
      if (skid_vld_q) skid_q <= res;
    end else if (emit) begin
      skid_q <= res;
    end
  end

  a_skid_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_if.ready))
    else $error("skid filled without a stall");
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !acc)
    else $error("item accepted with full skid");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared without reset");
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.status != dpsd_pkg::ST_OK) |=> halt_q)
    else $error("error record without halt");

endmodule
